// ----- rtl/priority_inheritance_lock_unit_assert.svh -----
// Assertion macros used by the lock unit checker.
`ifndef PRIORITY_INHERITANCE_LOCK_UNIT_ASSERT_SVH
`define PRIORITY_INHERITANCE_LOCK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PILU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define PILU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ----- rtl/pilu_pkg.sv -----
// Package: widths, status and function codes, types and controller command struct of the lock unit.
`default_nettype none
package pilu_pkg;
    localparam int TaskW   = 15;
    localparam int PrioW   = 8;
    localparam int StatusW = 3;

    localparam logic [StatusW-1:0] ST_GRANTED  = 3'd0;
    localparam logic [StatusW-1:0] ST_QUEUED   = 3'd1;
    localparam logic [StatusW-1:0] ST_FULL     = 3'd2;
    localparam logic [StatusW-1:0] ST_RELEASED = 3'd3;
    localparam logic [StatusW-1:0] ST_FREE_ERR = 3'd4;

    localparam logic FUNC_LOCK   = 1'b0;
    localparam logic FUNC_UNLOCK = 1'b1;

    typedef logic [TaskW-1:0]   t_task;
    typedef logic [PrioW-1:0]   t_prio;
    typedef logic [StatusW-1:0] t_status;

    typedef struct packed {
        logic load_in;
        logic exec;
    } t_cmd;
endpackage
`default_nettype wire

// ----- rtl/pilu_ctrl.sv -----
// Controller: sequences capture and execution of one request and owns result valid.
`default_nettype none
module pilu_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output pilu_pkg::t_cmd   o_cmd
);
    import pilu_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    // result slot can take a new beat when empty or draining this cycle
    assign out_free      = !r_out_valid || !i_out_stall;
    assign o_cmd.load_in = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC) && out_free;
    // hold off input beats while reset is asserted
    assign o_in_stall    = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid   = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: if (out_free)   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        priority if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/pilu_datapath.sv -----
// Datapath: request capture, holder state, sorted shifting wait queue, result registers.
`default_nettype none
module pilu_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  pilu_pkg::t_cmd   i_cmd,
    input  wire              i_func,
    input  pilu_pkg::t_task  i_task_id,
    input  pilu_pkg::t_prio  i_task_prio,
    output pilu_pkg::t_status o_status,
    output logic             o_prio_change_valid,
    output pilu_pkg::t_task  o_prio_change_task,
    output pilu_pkg::t_prio  o_changed_prio,
    output logic             o_woken_valid,
    output pilu_pkg::t_task  o_woken_task
);
    import pilu_pkg::*;

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

    // captured request
    logic  r_func;
    t_task r_task;
    t_prio r_prio;

    // holder state
    logic  r_busy, n_busy;
    t_task r_hold_task, n_hold_task;
    t_prio r_hold_base, n_hold_base;
    t_prio r_hold_cur, n_hold_cur;
    logic [CntW-1:0] r_count, n_count;

    // wait queue cells, most urgent at index 0
    t_prio r_wprio [QUEUE_DEPTH];
    t_task r_wtask [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] le;

    // result registers
    t_status r_status, n_status;
    logic    r_chg_v, n_chg_v;
    t_task   r_chg_t, n_chg_t;
    t_prio   r_chg_p, n_chg_p;
    logic    r_wk_v, n_wk_v;
    t_task   r_wk_t, n_wk_t;

    logic do_insert, do_pop;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= i_func;
            r_task <= i_task_id;
            r_prio <= i_task_prio;
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_hold_task = r_hold_task;
        n_hold_base = r_hold_base;
        n_hold_cur  = r_hold_cur;
        n_count     = r_count;
        n_status    = ST_GRANTED;
        n_chg_v     = 1'b0;
        n_chg_t     = '0;
        n_chg_p     = '0;
        n_wk_v      = 1'b0;
        n_wk_t      = '0;
        do_insert   = 1'b0;
        do_pop      = 1'b0;
        unique case (r_func)
            FUNC_LOCK: begin
                if (!r_busy) begin
                    n_busy      = 1'b1;
                    n_hold_task = r_task;
                    n_hold_base = r_prio;
                    n_hold_cur  = r_prio;
                    n_status    = ST_GRANTED;
                end else begin
                    if (r_count < DepthC) begin
                        do_insert = 1'b1;
                        n_count   = r_count + 1'b1;
                        n_status  = ST_QUEUED;
                    end else begin
                        n_status  = ST_FULL;
                    end
                    // boost the holder even when the queue is full
                    if (r_prio < r_hold_cur) begin
                        n_hold_cur = r_prio;
                        n_chg_v    = 1'b1;
                        n_chg_t    = r_hold_task;
                        n_chg_p    = r_prio;
                    end
                end
            end
            FUNC_UNLOCK: begin
                if (!r_busy) begin
                    n_status = ST_FREE_ERR;
                end else begin
                    if (r_hold_cur != r_hold_base) begin
                        n_chg_v = 1'b1;
                        n_chg_t = r_hold_task;
                        n_chg_p = r_hold_base;
                    end
                    n_busy      = 1'b0;
                    n_hold_task = '0;
                    n_hold_base = '0;
                    n_hold_cur  = '0;
                    if (r_count != '0) begin
                        do_pop  = 1'b1;
                        n_wk_v  = 1'b1;
                        n_wk_t  = r_wtask[0];
                        n_count = r_count - 1'b1;
                    end
                    n_status = ST_RELEASED;
                end
            end
            default: n_status = ST_GRANTED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_hold_task <= '0;
            r_hold_base <= '0;
            r_hold_cur  <= '0;
            r_count     <= '0;
        end else if (i_cmd.exec) begin
            r_busy      <= n_busy;
            r_hold_task <= n_hold_task;
            r_hold_base <= n_hold_base;
            r_hold_cur  <= n_hold_cur;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_chg_v  <= n_chg_v;
            r_chg_t  <= n_chg_t;
            r_chg_p  <= n_chg_p;
            r_wk_v   <= n_wk_v;
            r_wk_t   <= n_wk_t;
        end
    end

    // each cell compares its own entry; the true cells form a prefix (ties stay ahead)
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        logic ins_here, shift_in;
        assign le[k] = (CntW'(k) < r_count) && (r_wprio[k] <= r_prio);
        if (k == 0) begin : g_head
            assign ins_here = !le[0];
            assign shift_in = 1'b0;
        end else begin : g_body
            assign ins_here = le[k-1] && !le[k];
            assign shift_in = !le[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec && do_insert) begin
                if (ins_here) begin
                    r_wprio[k] <= r_prio;
                    r_wtask[k] <= r_task;
                end else if (shift_in) begin
                    if (k > 0) begin
                        r_wprio[k] <= r_wprio[(k > 0) ? k-1 : 0];
                        r_wtask[k] <= r_wtask[(k > 0) ? k-1 : 0];
                    end
                end
            end else if (i_cmd.exec && do_pop) begin
                // advance every entry toward the head
                if (k < QUEUE_DEPTH-1) begin
                    r_wprio[k] <= r_wprio[(k < QUEUE_DEPTH-1) ? k+1 : k];
                    r_wtask[k] <= r_wtask[(k < QUEUE_DEPTH-1) ? k+1 : k];
                end
            end
        end
    end

    assign o_status            = r_status;
    assign o_prio_change_valid = r_chg_v;
    assign o_prio_change_task  = r_chg_t;
    assign o_changed_prio      = r_chg_p;
    assign o_woken_valid       = r_wk_v;
    assign o_woken_task        = r_wk_t;
endmodule
`default_nettype wire

// ----- rtl/priority_inheritance_lock_unit.sv -----
// Priority-inheritance lock unit with one mutex and a priority-sorted wait queue.
// Input channel: i_in_valid / o_in_stall carry lock (func 0) and unlock (func 1)
//   requests with task id and priority; a lower priority number is more urgent.
// Output channel: o_out_valid / i_out_stall carry exactly one result beat per
//   request: status, optional holder priority change, optional woken waiter.
// Sequence: a request accepted in S_IDLE is captured, then executed in S_EXEC
//   once the result slot is free; the result beat is registered.
// A new request is not accepted until the previous one has executed; the capture
//   and execute states of the single controller state machine set this. The wait
//   queue is a row of shifting cells, so insert and pop finish in the execute
//   cycle regardless of QUEUE_DEPTH.
// A new request is taken while the previous result still waits in the output
//   register; a stalled receiver holds the result and then holds execution
//   of the next request, so o_in_stall stays high until the result drains.
// Reset (synchronous, active low) frees the mutex, clears the holder and
//   empties the queue; no clearing pass is needed. o_in_stall is high while
//   reset is asserted.
`default_nettype none
module priority_inheritance_lock_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire               i_func,
    input  pilu_pkg::t_task   i_task_id,
    input  pilu_pkg::t_prio   i_task_prio,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output pilu_pkg::t_status o_status,
    output logic              o_prio_change_valid,
    output pilu_pkg::t_task   o_prio_change_task,
    output pilu_pkg::t_prio   o_changed_prio,
    output logic              o_woken_valid,
    output pilu_pkg::t_task   o_woken_task
);
    import pilu_pkg::*;

    t_cmd cmd;

    pilu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    pilu_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_func              (i_func),
        .i_task_id           (i_task_id),
        .i_task_prio         (i_task_prio),
        .o_status            (o_status),
        .o_prio_change_valid (o_prio_change_valid),
        .o_prio_change_task  (o_prio_change_task),
        .o_changed_prio      (o_changed_prio),
        .o_woken_valid       (o_woken_valid),
        .o_woken_task        (o_woken_task)
    );
endmodule
`default_nettype wire

// ----- rtl/pilu_checker.sv -----
// Port-level checker for the lock unit and its bind to the top level.
`default_nettype none
`include "priority_inheritance_lock_unit_assert.svh"
module pilu_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_stall,
    input wire               o_out_valid,
    input wire               i_out_stall,
    input pilu_pkg::t_status o_status,
    input wire               o_prio_change_valid,
    input wire               o_woken_valid
);
    import pilu_pkg::*;

    // a stalled result beat stays
    `PILU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    // only an unlock of a busy mutex can wake a waiter
    `PILU_ASSERT_IMPLY(a_wake_on_release, i_clk, i_rst_n, o_out_valid && o_woken_valid, o_status == ST_RELEASED)
    // a grant never changes a priority or wakes anyone
    `PILU_ASSERT_IMPLY(a_grant_clean, i_clk, i_rst_n, o_out_valid && o_status == ST_GRANTED, !o_prio_change_valid && !o_woken_valid)
    // an unlock while free reports nothing else
    `PILU_ASSERT_IMPLY(a_err_clean, i_clk, i_rst_n, o_out_valid && o_status == ST_FREE_ERR, !o_prio_change_valid && !o_woken_valid)
    // an accepted request is never accepted again in the following cycle
    `PILU_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
endmodule

bind priority_inheritance_lock_unit pilu_checker u_pilu_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_status            (o_status),
    .o_prio_change_valid (o_prio_change_valid),
    .o_woken_valid       (o_woken_valid)
);
`default_nettype wire

// ----- test/priority_inheritance_lock_unit_tb.sv -----
// Self-checking testbench for the priority-inheritance lock unit: directed table, then random traffic.
`default_nettype none
module priority_inheritance_lock_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pilu_pkg::*;

    localparam int WAIT_DEPTH = 16;
    localparam int DIR_N      = 25;
    localparam int RAND_N     = 1350;

    typedef struct packed {
        t_status status;
        logic    chg_valid;
        t_task   chg_task;
        t_prio   chg_prio;
        logic    wake_valid;
        t_task   wake_task;
    } t_lock_result;

    typedef struct packed {
        logic         fn;
        t_task        tid;
        t_prio        pr;
        logic         typed;
        t_lock_result res;
    } t_dir_row;

    localparam t_lock_result UNTYPED = '0;

    // Rows with typed set carry their own result; the rest go through the predictor.
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{FUNC_UNLOCK, 15'd0,     8'd0,   1'b1, '{ST_FREE_ERR, 1'b0, 15'd0, 8'd0, 1'b0, 15'd0}},
        '{FUNC_LOCK,   15'd32767, 8'd255, 1'b1, '{ST_GRANTED, 1'b0, 15'd0, 8'd0, 1'b0, 15'd0}},
        '{FUNC_LOCK,   15'd0,     8'd0,   1'b1,
          '{ST_QUEUED, 1'b1, 15'd32767, 8'd0, 1'b0, 15'd0}},
        '{FUNC_UNLOCK, 15'd32767, 8'd255, 1'b1,
          '{ST_RELEASED, 1'b1, 15'd32767, 8'd255, 1'b1, 15'd0}},
        '{FUNC_LOCK,   15'd100,   8'd139, 1'b1, '{ST_GRANTED, 1'b0, 15'd0, 8'd0, 1'b0, 15'd0}},
        '{FUNC_LOCK,   15'd21845, 8'd139, 1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd10922, 8'd50,  1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd3,     8'd50,  1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd4,     8'd120, 1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd5,     8'd200, 1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd6,     8'd7,   1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd7,     8'd50,  1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd8,     8'd255, 1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd9,     8'd90,  1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd10,    8'd3,   1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd11,    8'd3,   1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd12,    8'd60,  1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd13,    8'd139, 1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd14,    8'd10,  1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd15,    8'd1,   1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd16,    8'd128, 1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd30000, 8'd0,   1'b1,
          '{ST_FULL, 1'b1, 15'd100, 8'd0, 1'b0, 15'd0}},
        '{FUNC_UNLOCK, 15'd12345, 8'd77,  1'b0, UNTYPED},
        '{FUNC_LOCK,   15'd4242,  8'd70,  1'b1, '{ST_GRANTED, 1'b0, 15'd0, 8'd0, 1'b0, 15'd0}},
        '{FUNC_LOCK,   15'd777,   8'd0,   1'b0, UNTYPED}
    };

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_in_valid  = 1'b0;
    logic    i_func      = FUNC_LOCK;
    t_task   i_task_id   = '0;
    t_prio   i_task_prio = '0;
    logic    i_out_stall = 1'b0;
    logic    o_in_stall;
    logic    o_out_valid;
    t_status o_status;
    logic    o_prio_change_valid;
    t_task   o_prio_change_task;
    t_prio   o_changed_prio;
    logic    o_woken_valid;
    t_task   o_woken_task;

    priority_inheritance_lock_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_func              (i_func),
        .i_task_id           (i_task_id),
        .i_task_prio         (i_task_prio),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_prio_change_valid (o_prio_change_valid),
        .o_prio_change_task  (o_prio_change_task),
        .o_changed_prio      (o_changed_prio),
        .o_woken_valid       (o_woken_valid),
        .o_woken_task        (o_woken_task)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow state of the mutex and its wait queue.
    logic  lock_busy;
    t_task owner_task;
    t_prio owner_base;
    t_prio owner_cur;
    t_prio wait_prio [WAIT_DEPTH];
    t_task wait_task [WAIT_DEPTH];
    int    wait_cnt;

    t_lock_result expected_results [$];
    int           err_cnt  = 0;
    bit           in_rush  = 1'b0;
    bit           out_rush = 1'b0;

    function automatic t_lock_result apply_request(logic fn, t_task tid, t_prio pr);
        t_lock_result r;
        int pos;
        r = '0;
        if (fn == FUNC_LOCK) begin
            if (!lock_busy) begin
                lock_busy  = 1'b1;
                owner_task = tid;
                owner_base = pr;
                owner_cur  = pr;
                r.status   = ST_GRANTED;
            end else begin
                if (wait_cnt < WAIT_DEPTH) begin
                    // sorted insert, equal priorities stay in arrival order
                    pos = 0;
                    while (pos < wait_cnt && wait_prio[pos] <= pr) pos++;
                    for (int k = wait_cnt; k > pos; k--) begin
                        wait_prio[k] = wait_prio[k-1];
                        wait_task[k] = wait_task[k-1];
                    end
                    wait_prio[pos] = pr;
                    wait_task[pos] = tid;
                    wait_cnt++;
                    r.status = ST_QUEUED;
                end else begin
                    r.status = ST_FULL;
                end
                if (pr < owner_cur) begin
                    owner_cur   = pr;
                    r.chg_valid = 1'b1;
                    r.chg_task  = owner_task;
                    r.chg_prio  = pr;
                end
            end
        end else if (!lock_busy) begin
            r.status = ST_FREE_ERR;
        end else begin
            if (owner_cur != owner_base) begin
                r.chg_valid = 1'b1;
                r.chg_task  = owner_task;
                r.chg_prio  = owner_base;
            end
            lock_busy  = 1'b0;
            owner_task = '0;
            owner_base = '0;
            owner_cur  = '0;
            if (wait_cnt > 0) begin
                r.wake_valid = 1'b1;
                r.wake_task  = wait_task[0];
                for (int k = 1; k < wait_cnt; k++) begin
                    wait_prio[k-1] = wait_prio[k];
                    wait_task[k-1] = wait_task[k];
                end
                wait_cnt--;
            end
            r.status = ST_RELEASED;
        end
        return r;
    endfunction

    // Drive one request beat and log its expected result once accepted.
    task automatic send_request(logic fn, t_task tid, t_prio pr, bit typed, t_lock_result res);
        int gap;
        t_lock_result pred;
        if ($urandom_range(0, 31) == 0) in_rush = !in_rush;
        gap = in_rush ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= fn;
        i_task_id   <= tid;
        i_task_prio <= pr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = apply_request(fn, tid, pr);
        expected_results.push_back(typed ? res : pred);
    endtask

    function automatic t_prio pick_prio();
        case ($urandom_range(0, 9))
            0:       return t_prio'($urandom_range(0, 255));
            1, 2:    return t_prio'($urandom_range(0, 3) * 40);
            default: return t_prio'($urandom_range(0, 139));
        endcase
    endfunction

    initial begin
        int   mode;
        int   mode_left;
        logic fn;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        lock_busy  = 1'b0;
        owner_task = '0;
        owner_base = '0;
        owner_cur  = '0;
        wait_cnt   = 0;
        @(posedge i_clk);

        foreach (DIR_ROWS[i])
            send_request(DIR_ROWS[i].fn, DIR_ROWS[i].tid, DIR_ROWS[i].pr,
                         DIR_ROWS[i].typed, DIR_ROWS[i].res);

        // fill, drain and mixed stretches keep the queue moving between empty and full
        mode      = 0;
        mode_left = 0;
        for (int n = 0; n < RAND_N; n++) begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(8, 40);
            end
            mode_left--;
            case (mode)
                0:       fn = ($urandom_range(0, 99) < 15) ? FUNC_UNLOCK : FUNC_LOCK;
                1:       fn = ($urandom_range(0, 99) < 75) ? FUNC_UNLOCK : FUNC_LOCK;
                default: fn = ($urandom_range(0, 1) == 1) ? FUNC_UNLOCK : FUNC_LOCK;
            endcase
            send_request(fn, t_task'($urandom_range(0, 32767)), pick_prio(), 1'b0, UNTYPED);
        end
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Result-side backpressure: hold stall for a random count before each beat.
    initial begin
        int hold;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) out_rush = !out_rush;
            hold = out_rush ? 0 : $urandom_range(0, 15);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_lock_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no request outstanding");
                err_cnt++;
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_cnt++;
                end
                if (o_prio_change_valid !== want.chg_valid) begin
                    $error("prio_change_valid: expected %0d, got %0d",
                           want.chg_valid, o_prio_change_valid);
                    err_cnt++;
                end
                if (o_prio_change_task !== want.chg_task) begin
                    $error("prio_change_task: expected %0d, got %0d",
                           want.chg_task, o_prio_change_task);
                    err_cnt++;
                end
                if (o_changed_prio !== want.chg_prio) begin
                    $error("changed_prio: expected %0d, got %0d",
                           want.chg_prio, o_changed_prio);
                    err_cnt++;
                end
                if (o_woken_valid !== want.wake_valid) begin
                    $error("woken_valid: expected %0d, got %0d", want.wake_valid, o_woken_valid);
                    err_cnt++;
                end
                if (o_woken_task !== want.wake_task) begin
                    $error("woken_task: expected %0d, got %0d", want.wake_task, o_woken_task);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
